### sv/ppds_pkg.sv
`default_nettype none

package ppds_pkg;

  // command codes on the cmd port
  localparam logic [2:0] CMD_PAL_RAW = 3'd0;
  localparam logic [2:0] CMD_PAL_RGB = 3'd1;
  localparam logic [2:0] CMD_FB_WRITE = 3'd2;
  localparam logic [2:0] CMD_START = 3'd3;
  localparam logic [2:0] CMD_TICK = 3'd4;

  // framebuffer select width, enough for the largest buffer count
  localparam int SEL_W = 2;

  typedef enum logic [1:0] {
    OP_PAL,
    OP_FB,
    OP_START,
    OP_TICK
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_EMIT
  } state_t;

  // one classified word waiting for the scanner
  typedef struct packed {
    op_t              op;
    logic [SEL_W-1:0] sel;
    logic [14:0]      addr;
    logic [7:0]       value;
    logic [15:0]      color;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

### sv/ppds_front.sv
`default_nettype none

module ppds_front #(
  parameter int FB_PIXELS = 25600,
  parameter int NUM_BUFFERS = 2,
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic                start,
  input  wire logic                busy,
  input  wire logic [2:0]          cmd,
  input  wire logic                buffer_sel,
  input  wire logic [14:0]         pixel_address,
  input  wire logic [7:0]          pixel_value,
  input  wire logic [7:0]          pal_slot,
  input  wire logic [15:0]         color_word,
  input  wire logic [7:0]          red,
  input  wire logic [7:0]          green,
  input  wire logic [7:0]          blue,
  output logic                     push,
  output ppds_pkg::entry_t         entry
);

  localparam logic [7:0] BLUE_MASK = 8'hF8;
  localparam logic [7:0] GREEN_MASK = 8'hFC;

  logic accept;
  logic addr_ok;
  logic pal_ok;
  logic [15:0] rgb_color;
  logic [15:0] packed_rgb;

  assign accept = start && !busy;
  assign addr_ok = {17'd0, pixel_address} < 32'(FB_PIXELS);
  assign pal_ok = {24'd0, pal_slot} < 32'(PALETTE_DEPTH);

  // blue on top, then green, then red, all inverted
  assign packed_rgb = ({(blue & BLUE_MASK), 8'h00})
                    | ({8'h00, (green & GREEN_MASK)} << 3)
                    | {8'h00, (red >> 3)};
  assign rgb_color = ~packed_rgb;

  always_comb begin
    entry.op = ppds_pkg::OP_TICK;
    entry.sel = (NUM_BUFFERS > 1) ? ppds_pkg::SEL_W'(buffer_sel) : '0;
    entry.addr = pixel_address;
    entry.value = pixel_value;
    entry.color = color_word;
    push = 1'b0;
    case (cmd)
      ppds_pkg::CMD_PAL_RAW: begin
        entry.op = ppds_pkg::OP_PAL;
        entry.value = pal_slot;
        push = accept && pal_ok;
      end
      ppds_pkg::CMD_PAL_RGB: begin
        entry.op = ppds_pkg::OP_PAL;
        entry.value = pal_slot;
        entry.color = rgb_color;
        push = accept && pal_ok;
      end
      ppds_pkg::CMD_FB_WRITE: begin
        entry.op = ppds_pkg::OP_FB;
        push = accept && addr_ok;
      end
      ppds_pkg::CMD_START: begin
        entry.op = ppds_pkg::OP_START;
        push = accept;
      end
      ppds_pkg::CMD_TICK: begin
        entry.op = ppds_pkg::OP_TICK;
        push = accept;
      end
      default: begin
        // drop unknown commands
        push = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/ppds_fifo.sv
`default_nettype none

module ppds_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire ppds_pkg::entry_t  din,
  input  wire logic              pop,
  output ppds_pkg::entry_t       head,
  output ppds_pkg::q_stat_t      stat
);

  ppds_pkg::entry_t slots [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic do_push;
  logic do_pop;

  assign stat.full = (count == 2'd2);
  assign stat.empty = (count == 2'd0);
  assign do_push = push && !stat.full;
  assign do_pop = pop && !stat.empty;
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/ppds_back.sv
`default_nettype none

module ppds_back #(
  parameter int FB_WIDTH = 160,
  parameter int FB_HEIGHT = 160,
  parameter int NUM_BUFFERS = 2,
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ppds_pkg::entry_t  head,
  input  wire ppds_pkg::q_stat_t q_stat,
  output logic                   pop,
  output logic                   strobe,
  output logic [7:0]             bus_byte,
  output logic                   is_high_byte,
  output logic                   last_of_frame
);

  localparam int FB_PIXELS = FB_WIDTH * FB_HEIGHT;
  localparam int FB_DEPTH = NUM_BUFFERS * FB_PIXELS;
  localparam int FB_AW = $clog2(FB_DEPTH);
  localparam int POS_W = $clog2(FB_PIXELS);
  localparam int COL_W = $clog2(FB_WIDTH);
  localparam int PAL_W = $clog2(PALETTE_DEPTH);
  localparam logic [FB_AW-1:0] PIX_C = FB_AW'(FB_PIXELS);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FB_PIXELS - 1);
  localparam logic [POS_W-1:0] ROW_BACK = POS_W'(FB_WIDTH - 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(FB_WIDTH - 1);

  ppds_pkg::state_t state, state_next;

  logic [7:0] fb_mem [FB_DEPTH];
  logic [15:0] pal_mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] pal_vld;

  logic [7:0] fb_q;
  logic [15:0] pal_q;
  logic pal_q_ok;
  logic idx_ok;

  logic scan_active, scan_active_next;
  logic [ppds_pkg::SEL_W-1:0] scan_sel, scan_sel_next;
  logic [POS_W-1:0] scan_pos, scan_pos_next;
  logic [COL_W-1:0] scan_col, scan_col_next;
  logic row_repeat_done, row_repeat_done_next;
  logic pixel_copy, pixel_copy_next;
  logic byte_phase, byte_phase_next;
  logic [15:0] current_color, current_color_next;

  logic is_tick;
  logic need_fetch;
  logic emit;
  logic last_now;
  logic [15:0] color_now;
  logic [FB_AW-1:0] scan_addr;
  logic [FB_AW-1:0] wr_addr;

  assign is_tick = !q_stat.empty && (head.op == ppds_pkg::OP_TICK) && scan_active;
  assign need_fetch = !byte_phase && !pixel_copy;
  assign scan_addr = FB_AW'(scan_sel) * PIX_C + FB_AW'(scan_pos);
  assign wr_addr = FB_AW'(head.sel) * PIX_C + FB_AW'(head.addr);
  assign idx_ok = {24'd0, fb_q} < 32'(PALETTE_DEPTH);

  // framebuffer: write from the queue, read the scan address every cycle
  always_ff @(posedge clk) begin
    if (pop && head.op == ppds_pkg::OP_FB) begin
      fb_mem[wr_addr] <= head.value;
    end
    fb_q <= fb_mem[scan_addr];
  end

  // palette: read at the index the framebuffer just returned
  always_ff @(posedge clk) begin
    if (pop && head.op == ppds_pkg::OP_PAL) begin
      pal_mem[head.value[PAL_W-1:0]] <= head.color;
    end
    pal_q <= pal_mem[fb_q[PAL_W-1:0]];
  end

  // unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      pal_vld <= '0;
      pal_q_ok <= 1'b0;
    end else begin
      if (pop && head.op == ppds_pkg::OP_PAL) begin
        pal_vld[head.value[PAL_W-1:0]] <= 1'b1;
      end
      pal_q_ok <= idx_ok && pal_vld[fb_q[PAL_W-1:0]];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ppds_pkg::BK_IDLE: begin
        if (is_tick && need_fetch) begin
          state_next = ppds_pkg::BK_FETCH;
        end
      end
      ppds_pkg::BK_FETCH: state_next = ppds_pkg::BK_EMIT;
      ppds_pkg::BK_EMIT: state_next = ppds_pkg::BK_IDLE;
      default: state_next = ppds_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    emit = 1'b0;
    case (state)
      ppds_pkg::BK_IDLE: begin
        pop = !q_stat.empty;
        emit = is_tick && !need_fetch;
      end
      ppds_pkg::BK_FETCH: begin
        pop = 1'b0;
        emit = 1'b0;
      end
      ppds_pkg::BK_EMIT: begin
        pop = 1'b0;
        emit = 1'b1;
      end
      default: begin
        pop = 1'b0;
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    scan_active_next = scan_active;
    scan_sel_next = scan_sel;
    scan_pos_next = scan_pos;
    scan_col_next = scan_col;
    row_repeat_done_next = row_repeat_done;
    pixel_copy_next = pixel_copy;
    byte_phase_next = byte_phase;
    current_color_next = current_color;
    last_now = 1'b0;
    color_now = current_color;
    if (state == ppds_pkg::BK_EMIT) begin
      color_now = pal_q_ok ? pal_q : 16'h0000;
      current_color_next = color_now;
    end
    if (pop && head.op == ppds_pkg::OP_START) begin
      scan_active_next = 1'b1;
      scan_sel_next = head.sel;
      scan_pos_next = LAST_POS;
      scan_col_next = LAST_COL;
      row_repeat_done_next = 1'b0;
      pixel_copy_next = 1'b0;
      byte_phase_next = 1'b0;
    end else if (emit) begin
      if (byte_phase) begin
        if (pixel_copy) begin
          if (scan_col == '0) begin
            if (!row_repeat_done) begin
              // rewind to the end of the row for its second pass
              row_repeat_done_next = 1'b1;
              scan_pos_next = scan_pos + ROW_BACK;
              scan_col_next = LAST_COL;
            end else begin
              row_repeat_done_next = 1'b0;
              if (scan_pos == '0) begin
                last_now = 1'b1;
                scan_active_next = 1'b0;
              end else begin
                scan_pos_next = scan_pos - POS_W'(1);
                scan_col_next = LAST_COL;
              end
            end
          end else begin
            scan_pos_next = scan_pos - POS_W'(1);
            scan_col_next = scan_col - COL_W'(1);
          end
        end
        pixel_copy_next = !pixel_copy;
      end
      byte_phase_next = !byte_phase;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppds_pkg::BK_IDLE;
      scan_active <= 1'b0;
      scan_sel <= '0;
      scan_pos <= '0;
      scan_col <= '0;
      row_repeat_done <= 1'b0;
      pixel_copy <= 1'b0;
      byte_phase <= 1'b0;
      current_color <= 16'h0000;
      strobe <= 1'b0;
    end else begin
      state <= state_next;
      scan_active <= scan_active_next;
      scan_sel <= scan_sel_next;
      scan_pos <= scan_pos_next;
      scan_col <= scan_col_next;
      row_repeat_done <= row_repeat_done_next;
      pixel_copy <= pixel_copy_next;
      byte_phase <= byte_phase_next;
      current_color <= current_color_next;
      strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      bus_byte <= byte_phase ? color_now[7:0] : color_now[15:8];
      is_high_byte <= !byte_phase;
      last_of_frame <= last_now;
    end
  end

  a_fetch_then_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ppds_pkg::BK_FETCH) |=> (state == ppds_pkg::BK_EMIT))
    else $error("fetch not followed by emit");

  a_emit_first_byte: assert property (@(posedge clk) disable iff (rst)
    (state == ppds_pkg::BK_EMIT) |-> (!byte_phase && !pixel_copy))
    else $error("palette fetch on a byte other than the first of a pixel");

  a_last_stops_scan: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_of_frame) |-> !scan_active)
    else $error("scan still active after the final byte");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from an empty queue");

  a_origin_column: assert property (@(posedge clk) disable iff (rst)
    (scan_pos == '0) |-> (scan_col == '0))
    else $error("column counter out of step with position");

endmodule

`default_nettype wire

### sv/palette_pixel_doubling_scanout_unit.sv
// Flow: a word accepted into the queue is popped by the scanner while it is idle; a tick
// that sends a stored color strobes its byte in the cycle after it is taken, a tick that
// starts a new pixel fetches framebuffer then palette and then sends its byte.
// Throughput: one word per cycle while the scanner is idle; a pixel's first tick holds the
// scanner through its framebuffer read, palette read and send steps.
// Reset clears the queue, the scanner and the palette (all entries read zero); framebuffer
// contents are kept. Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none

module palette_pixel_doubling_scanout_unit #(
  parameter int FB_WIDTH = 160,
  parameter int FB_HEIGHT = 160,
  parameter int NUM_BUFFERS = 2,
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  cmd,
  input  wire logic        buffer_sel,
  input  wire logic [14:0] pixel_address,
  input  wire logic [7:0]  pixel_value,
  input  wire logic [7:0]  pal_slot,
  input  wire logic [15:0] color_word,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  output logic             strobe,
  output logic [7:0]       bus_byte,
  output logic             is_high_byte,
  output logic             last_of_frame
);

  logic push;
  logic pop;
  ppds_pkg::entry_t entry;
  ppds_pkg::entry_t head;
  ppds_pkg::q_stat_t q_stat;

  assign busy = q_stat.full;

  ppds_front #(
    .FB_PIXELS     (FB_WIDTH * FB_HEIGHT),
    .NUM_BUFFERS   (NUM_BUFFERS),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .buffer_sel    (buffer_sel),
    .pixel_address (pixel_address),
    .pixel_value   (pixel_value),
    .pal_slot      (pal_slot),
    .color_word    (color_word),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .push          (push),
    .entry         (entry)
  );

  ppds_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (entry),
    .pop  (pop),
    .head (head),
    .stat (q_stat)
  );

  ppds_back #(
    .FB_WIDTH      (FB_WIDTH),
    .FB_HEIGHT     (FB_HEIGHT),
    .NUM_BUFFERS   (NUM_BUFFERS),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_stat        (q_stat),
    .pop           (pop),
    .strobe        (strobe),
    .bus_byte      (bus_byte),
    .is_high_byte  (is_high_byte),
    .last_of_frame (last_of_frame)
  );

endmodule

`default_nettype wire
